>>> rtl/finvt_pkg.sv
// finvt_pkg: shared constants, types and fixed-point helpers
// depends on nothing
package finvt_pkg;

    localparam int CW = 20;
    localparam int FB = 16;
    localparam int VW = 32;
    localparam int PW = 3 * CW;

    localparam logic [2:0] REG_POINT  = 3'd0;
    localparam logic [2:0] REG_NODE_A = 3'd1;
    localparam logic [2:0] REG_NODE_B = 3'd2;
    localparam logic [2:0] REG_NRM_A  = 3'd3;
    localparam logic [2:0] REG_NRM_B  = 3'd4;
    localparam logic [2:0] REG_OFFSET = 3'd5;

    typedef logic signed [VW-1:0] val_t;
    typedef val_t vec_t [3];

    function automatic val_t sat(input logic signed [VW+1:0] v);
        val_t r;
        if (v > 34'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            r = -32'sh8000_0000;
        else
            r = val_t'(v);
        return r;
    endfunction

    // product rounded half up, then clamped
    function automatic val_t mulq(input val_t a, input val_t b);
        logic signed [2*VW-1:0] p;
        logic signed [2*VW-1:0] q;
        p = a * b + (64'sd1 <<< (FB - 1));
        q = p >>> FB;
        if (q > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (q < -64'sh8000_0000)
            return -32'sh8000_0000;
        return val_t'(q);
    endfunction

    function automatic val_t add(input val_t a, input val_t b);
        return sat(34'(a) + 34'(b));
    endfunction

    function automatic val_t sub(input val_t a, input val_t b);
        return sat(34'(a) - 34'(b));
    endfunction

    function automatic val_t ext(input logic [CW-1:0] v);
        return val_t'($signed(v));
    endfunction

endpackage

>>> rtl/finvt_if.sv
// finvt stream and config channel interfaces
// depends on finvt_pkg
interface finvt_in_if;
    logic valid;
    logic ready;
    logic signed [finvt_pkg::CW-1:0] coord_s;
    logic signed [finvt_pkg::CW-1:0] coord_t;
    logic signed [finvt_pkg::CW-1:0] dist_d;
    modport source (output valid, coord_s, coord_t, dist_d, input ready);
    modport sink (input valid, coord_s, coord_t, dist_d, output ready);
endinterface

interface finvt_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] res_x, res_y, res_z;
    logic signed [31:0] jac_x_s, jac_x_t, jac_x_d;
    logic signed [31:0] jac_y_s, jac_y_t, jac_y_d;
    logic signed [31:0] jac_z_s, jac_z_t, jac_z_d;
    modport source (output valid, res_x, res_y, res_z, jac_x_s, jac_x_t, jac_x_d,
        jac_y_s, jac_y_t, jac_y_d, jac_z_s, jac_z_t, jac_z_d, input ready);
    modport sink (input valid, res_x, res_y, res_z, jac_x_s, jac_x_t, jac_x_d,
        jac_y_s, jac_y_t, jac_y_d, jac_z_s, jac_z_t, jac_z_d, output ready);
endinterface

interface finvt_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/face_influence_volume_newton_terms_core.sv
// face_influence_volume_newton_terms_core: Newton residual and Jacobian pipeline
// depends on finvt_pkg and the finvt interfaces
//
//  channel   dir  carries
//  cfg       in   register index, write data
//  in_ch     in   coord_s, coord_t, dist_d
//  out_ch    out  residual and 3x3 Jacobian
//
// one item per cycle while out_ch is not stalled; six register stages
// each stage holds at most one rounded multiply on any path
// a stall holds the full stages from the output back to the first bubble; a bubble stage still fills while stalled
// rst_n clears valid bits and config registers
module face_influence_volume_newton_terms_core (
    input logic clk,
    input logic rst_n,
    finvt_cfg_if.sink cfg,
    finvt_in_if.sink in_ch,
    finvt_out_if.source out_ch
);
    localparam int NS = 6;

    logic [finvt_pkg::PW-1:0] pt_reg, a_reg, b_reg, na_reg, nb_reg;
    logic [finvt_pkg::CW-1:0] c_reg;
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] adv;

    finvt_pkg::vec_t pa, pb, pna, pnb, ppt;
    finvt_pkg::val_t pc;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_reg <= '0; a_reg <= '0; b_reg <= '0;
            na_reg <= '0; nb_reg <= '0; c_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                finvt_pkg::REG_POINT:  pt_reg <= cfg.data[finvt_pkg::PW-1:0];
                finvt_pkg::REG_NODE_A: a_reg <= cfg.data[finvt_pkg::PW-1:0];
                finvt_pkg::REG_NODE_B: b_reg <= cfg.data[finvt_pkg::PW-1:0];
                finvt_pkg::REG_NRM_A:  na_reg <= cfg.data[finvt_pkg::PW-1:0];
                finvt_pkg::REG_NRM_B:  nb_reg <= cfg.data[finvt_pkg::PW-1:0];
                finvt_pkg::REG_OFFSET: c_reg <= cfg.data[finvt_pkg::CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ppt[i] = finvt_pkg::ext(pt_reg[i*finvt_pkg::CW +: finvt_pkg::CW]);
            pa[i] = finvt_pkg::ext(a_reg[i*finvt_pkg::CW +: finvt_pkg::CW]);
            pb[i] = finvt_pkg::ext(b_reg[i*finvt_pkg::CW +: finvt_pkg::CW]);
            pna[i] = finvt_pkg::ext(na_reg[i*finvt_pkg::CW +: finvt_pkg::CW]);
            pnb[i] = finvt_pkg::ext(nb_reg[i*finvt_pkg::CW +: finvt_pkg::CW]);
        end
        pc = finvt_pkg::ext(c_reg);
    end

    // stall control: stage k moves when it is empty or the next stage moves
    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || out_ch.ready;
        for (int k = NS - 2; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end
    assign in_ch.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= in_ch.valid;
            for (int k = 1; k < NS; k++)
                if (adv[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    // stage 1: u, w, node differences, products with constants
    finvt_pkg::val_t s1_s_reg, s1_t_reg, s1_d_reg, s1_u_reg, s1_w_reg, s1_ct_reg;
    finvt_pkg::vec_t s1_cnb_reg, s1_cna_reg, s1_ba_reg, s1_nd_reg;
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_s_reg <= finvt_pkg::ext(in_ch.coord_s);
            s1_t_reg <= finvt_pkg::ext(in_ch.coord_t);
            s1_d_reg <= finvt_pkg::ext(in_ch.dist_d);
            s1_u_reg <= finvt_pkg::sub(32'sd1 <<< finvt_pkg::FB, finvt_pkg::ext(in_ch.coord_s));
            s1_w_reg <= finvt_pkg::sub(32'sd1 <<< finvt_pkg::FB, finvt_pkg::ext(in_ch.coord_t));
            s1_ct_reg <= finvt_pkg::mulq(pc, finvt_pkg::ext(in_ch.coord_t));
            for (int i = 0; i < 3; i++)
            begin
                s1_cnb_reg[i] <= finvt_pkg::mulq(pc, pnb[i]);
                s1_cna_reg[i] <= finvt_pkg::mulq(pc, pna[i]);
                s1_ba_reg[i] <= finvt_pkg::sub(pb[i], pa[i]);
                s1_nd_reg[i] <= finvt_pkg::sub(pnb[i], pna[i]);
            end
        end
    end

    // stage 2: weights, pseudo-nodes, v1/v2 partial products
    finvt_pkg::val_t s2_s_reg, s2_t_reg, s2_d_reg, s2_u_reg, s2_w_reg;
    finvt_pkg::val_t s2_n0_reg, s2_n1_reg, s2_n2_reg, s2_n3_reg;
    finvt_pkg::vec_t s2_p2_reg, s2_p3_reg, s2_ba_reg, s2_ctn_reg, s2_snb_reg, s2_una_reg;
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_s_reg <= s1_s_reg; s2_t_reg <= s1_t_reg; s2_d_reg <= s1_d_reg;
            s2_u_reg <= s1_u_reg; s2_w_reg <= s1_w_reg;
            s2_n0_reg <= finvt_pkg::mulq(s1_u_reg, s1_w_reg);
            s2_n1_reg <= finvt_pkg::mulq(s1_s_reg, s1_w_reg);
            s2_n2_reg <= finvt_pkg::mulq(s1_s_reg, s1_t_reg);
            s2_n3_reg <= finvt_pkg::mulq(s1_u_reg, s1_t_reg);
            for (int i = 0; i < 3; i++)
            begin
                s2_p2_reg[i] <= finvt_pkg::add(pb[i], s1_cnb_reg[i]);
                s2_p3_reg[i] <= finvt_pkg::add(pa[i], s1_cna_reg[i]);
                s2_ba_reg[i] <= s1_ba_reg[i];
                s2_ctn_reg[i] <= finvt_pkg::mulq(s1_ct_reg, s1_nd_reg[i]);
                s2_snb_reg[i] <= finvt_pkg::mulq(s1_s_reg, pnb[i]);
                s2_una_reg[i] <= finvt_pkg::mulq(s1_u_reg, pna[i]);
            end
        end
    end

    // stage 3: v1, v2, X terms, Jacobian terms
    // X partial sums stay unclamped so that X saturates once over all four terms
    finvt_pkg::val_t s3_d_reg;
    finvt_pkg::vec_t s3_v1_reg, s3_v2_reg, s3_js_reg, s3_jt_reg;
    logic signed [finvt_pkg::VW:0] s3_xa_reg [3];
    logic signed [finvt_pkg::VW:0] s3_xb_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_d_reg <= s2_d_reg;
            for (int i = 0; i < 3; i++)
            begin
                s3_v1_reg[i] <= finvt_pkg::add(s2_ba_reg[i], s2_ctn_reg[i]);
                s3_v2_reg[i] <= finvt_pkg::add(s2_snb_reg[i], s2_una_reg[i]);
                s3_xa_reg[i] <= 33'(finvt_pkg::mulq(s2_n0_reg, pa[i]))
                    + 33'(finvt_pkg::mulq(s2_n1_reg, pb[i]));
                s3_xb_reg[i] <= 33'(finvt_pkg::mulq(s2_n2_reg, s2_p2_reg[i]))
                    + 33'(finvt_pkg::mulq(s2_n3_reg, s2_p3_reg[i]));
                s3_js_reg[i] <= finvt_pkg::sat(
                    34'(finvt_pkg::mulq(s2_w_reg, s2_ba_reg[i]))
                    + 34'(finvt_pkg::mulq(s2_t_reg,
                        finvt_pkg::sub(s2_p2_reg[i], s2_p3_reg[i]))));
                s3_jt_reg[i] <= finvt_pkg::sat(
                    34'(finvt_pkg::mulq(s2_s_reg, finvt_pkg::sub(s2_p2_reg[i], pb[i])))
                    + 34'(finvt_pkg::mulq(s2_u_reg,
                        finvt_pkg::sub(s2_p3_reg[i], pa[i]))));
            end
        end
    end

    // stage 4: cross product halves; X as a full four-term sum
    finvt_pkg::val_t s4_d_reg;
    finvt_pkg::vec_t s4_cp_reg, s4_cm_reg, s4_x_reg, s4_js_reg, s4_jt_reg;
    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_d_reg <= s3_d_reg;
            for (int i = 0; i < 3; i++)
            begin
                s4_cp_reg[i] <= finvt_pkg::mulq(s3_v1_reg[(i+1)%3], s3_v2_reg[(i+2)%3]);
                s4_cm_reg[i] <= finvt_pkg::mulq(s3_v1_reg[(i+2)%3], s3_v2_reg[(i+1)%3]);
                s4_x_reg[i] <= finvt_pkg::sat(34'(s3_xa_reg[i]) + 34'(s3_xb_reg[i]));
                s4_js_reg[i] <= s3_js_reg[i];
                s4_jt_reg[i] <= s3_jt_reg[i];
            end
        end
    end

    // stage 5: normal
    finvt_pkg::val_t s5_d_reg;
    finvt_pkg::vec_t s5_n_reg, s5_x_reg, s5_js_reg, s5_jt_reg;
    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_d_reg <= s4_d_reg;
            for (int i = 0; i < 3; i++)
            begin
                s5_n_reg[i] <= finvt_pkg::sub(s4_cp_reg[i], s4_cm_reg[i]);
                s5_x_reg[i] <= s4_x_reg[i];
                s5_js_reg[i] <= s4_js_reg[i];
                s5_jt_reg[i] <= s4_jt_reg[i];
            end
        end
    end

    // stage 6: residual
    finvt_pkg::vec_t s6_r_reg, s6_n_reg, s6_js_reg, s6_jt_reg;
    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s6_r_reg[i] <= finvt_pkg::sat(34'(s5_x_reg[i])
                    + 34'(finvt_pkg::mulq(s5_d_reg, s5_n_reg[i])) - 34'(ppt[i]));
                s6_n_reg[i] <= s5_n_reg[i];
                s6_js_reg[i] <= s5_js_reg[i];
                s6_jt_reg[i] <= s5_jt_reg[i];
            end
        end
    end

    assign out_ch.valid = vld_reg[NS-1];
    assign out_ch.res_x = s6_r_reg[0];
    assign out_ch.res_y = s6_r_reg[1];
    assign out_ch.res_z = s6_r_reg[2];
    assign out_ch.jac_x_s = s6_js_reg[0];
    assign out_ch.jac_x_t = s6_jt_reg[0];
    assign out_ch.jac_x_d = s6_n_reg[0];
    assign out_ch.jac_y_s = s6_js_reg[1];
    assign out_ch.jac_y_t = s6_jt_reg[1];
    assign out_ch.jac_y_d = s6_n_reg[1];
    assign out_ch.jac_z_s = s6_js_reg[2];
    assign out_ch.jac_z_t = s6_jt_reg[2];
    assign out_ch.jac_z_d = s6_n_reg[2];

    // a stalled output stage keeps its item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("output item dropped under stall");
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg) && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken while pipeline full");
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.ready |-> in_ch.ready)
        else $error("pipeline stalled with free output");
endmodule
